### rtl/tfap_pkg.sv
// Shared types and constants for the field-aligned tensor projection.
package tfap_pkg;

	// Headroom of the quotient above the output width: |N/D| and |M/2D| stay below 3*2^(DW-1).
	localparam int unsigned QEXTRA = 2;

	typedef struct packed {
		logic zero;
		logic neg_par;
		logic neg_perp;
	} flags_t;

endpackage

### rtl/tfap_front.sv
// Front pipeline: products, field norm, trace and signed numerators, five stages.
module tfap_front #(
	parameter int DW = 32,
	parameter int FW = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [6*DW+3*FW-1:0]     in_data,
	output logic                     v_s5,
	output logic [DW+2*FW+3:0]       mag_par_s5,
	output logic [DW+2*FW+3:0]       mag_perp_s5,
	output logic [2*FW-1:0]          den_s5,
	output tfap_pkg::flags_t         flags_s5
);
	localparam int UW = DW + FW + 2;
	localparam int UL = UW / 2;
	localparam int UH = UW - UL;
	localparam int DD = 2 * FW;
	localparam int DL = DD / 2;
	localparam int DH = DD - DL;
	localparam int TW = DW + 2;
	localparam int NW = DW + 2 * FW + 4;

	logic signed [DW-1:0] txx, tyy, tzz, txy, tyz, tzx;
	logic signed [FW-1:0] bx, by, bz;

	assign txx = in_data[DW-1:0];
	assign tyy = in_data[2*DW-1:DW];
	assign tzz = in_data[3*DW-1:2*DW];
	assign txy = in_data[4*DW-1:3*DW];
	assign tyz = in_data[5*DW-1:4*DW];
	assign tzx = in_data[6*DW-1:5*DW];
	assign bx  = in_data[6*DW+FW-1:6*DW];
	assign by  = in_data[6*DW+2*FW-1:6*DW+FW];
	assign bz  = in_data[6*DW+3*FW-1:6*DW+2*FW];

	// Stage 1: u = T b, |B|^2 and the trace.
	logic signed [DW+FW-1:0] p0, p1, p2, p3, p4, p5, p6, p7, p8;
	logic signed [2*FW-1:0]  sq_x, sq_y, sq_z;
	logic signed [UW-1:0]    ux_c, uy_c, uz_c;
	logic [DD-1:0]           d_c;
	logic signed [TW-1:0]    tr_c;
	logic                    zero_c;

	assign p0 = txx * bx;
	assign p1 = txy * by;
	assign p2 = tzx * bz;
	assign p3 = txy * bx;
	assign p4 = tyy * by;
	assign p5 = tyz * bz;
	assign p6 = tzx * bx;
	assign p7 = tyz * by;
	assign p8 = tzz * bz;
	assign ux_c = UW'(p0) + UW'(p1) + UW'(p2);
	assign uy_c = UW'(p3) + UW'(p4) + UW'(p5);
	assign uz_c = UW'(p6) + UW'(p7) + UW'(p8);
	assign sq_x = bx * bx;
	assign sq_y = by * by;
	assign sq_z = bz * bz;
	assign d_c = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
	assign tr_c = TW'(txx) + TW'(tyy) + TW'(tzz);
	assign zero_c = (bx == '0) && (by == '0) && (bz == '0);

	logic                    v_s1;
	logic signed [UW-1:0]    ux_s1, uy_s1, uz_s1;
	logic [DD-1:0]           d_s1;
	logic signed [TW-1:0]    tr_s1;
	logic signed [FW-1:0]    bx_s1, by_s1, bz_s1;
	logic                    zero_s1;

	// Stage 2: b . u and tr * D, each split into two narrower products.
	logic signed [FW+UL:0]   pxl_c, pyl_c, pzl_c;
	logic signed [FW+UH-1:0] pxh_c, pyh_c, pzh_c;
	logic signed [TW+DL:0]   tdl_c;
	logic signed [TW+DH:0]   tdh_c;

	assign pxl_c = bx_s1 * $signed({1'b0, ux_s1[UL-1:0]});
	assign pyl_c = by_s1 * $signed({1'b0, uy_s1[UL-1:0]});
	assign pzl_c = bz_s1 * $signed({1'b0, uz_s1[UL-1:0]});
	assign pxh_c = bx_s1 * $signed(ux_s1[UW-1:UL]);
	assign pyh_c = by_s1 * $signed(uy_s1[UW-1:UL]);
	assign pzh_c = bz_s1 * $signed(uz_s1[UW-1:UL]);
	assign tdl_c = tr_s1 * $signed({1'b0, d_s1[DL-1:0]});
	assign tdh_c = tr_s1 * $signed({1'b0, d_s1[DD-1:DL]});

	logic                    v_s2;
	logic signed [FW+UL:0]   pxl_s2, pyl_s2, pzl_s2;
	logic signed [FW+UH-1:0] pxh_s2, pyh_s2, pzh_s2;
	logic signed [TW+DL:0]   tdl_s2;
	logic signed [TW+DH:0]   tdh_s2;
	logic [DD-1:0]           d_s2;
	logic                    zero_s2;

	// Stage 3: recombine the partial products.
	logic signed [NW-1:0] n_c, td_c;

	assign n_c = (NW'(pxh_s2) <<< UL) + NW'(pxl_s2) + (NW'(pyh_s2) <<< UL) + NW'(pyl_s2)
		+ (NW'(pzh_s2) <<< UL) + NW'(pzl_s2);
	assign td_c = (NW'(tdh_s2) <<< DL) + NW'(tdl_s2);

	logic                 v_s3;
	logic signed [NW-1:0] n_s3, td_s3;
	logic [DD-1:0]        d_s3;
	logic                 zero_s3;

	// Stage 4: perpendicular numerator tr*D - N.
	logic                 v_s4;
	logic signed [NW-1:0] n_s4, m_s4;
	logic [DD-1:0]        d_s4;
	logic                 zero_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1   <= ux_c;
			uy_s1   <= uy_c;
			uz_s1   <= uz_c;
			d_s1    <= d_c;
			tr_s1   <= tr_c;
			bx_s1   <= bx;
			by_s1   <= by;
			bz_s1   <= bz;
			zero_s1 <= zero_c;

			pxl_s2  <= pxl_c;
			pyl_s2  <= pyl_c;
			pzl_s2  <= pzl_c;
			pxh_s2  <= pxh_c;
			pyh_s2  <= pyh_c;
			pzh_s2  <= pzh_c;
			tdl_s2  <= tdl_c;
			tdh_s2  <= tdh_c;
			d_s2    <= d_s1;
			zero_s2 <= zero_s1;

			n_s3    <= n_c;
			td_s3   <= td_c;
			d_s3    <= d_s2;
			zero_s3 <= zero_s2;

			n_s4    <= n_s3;
			m_s4    <= td_s3 - n_s3;
			d_s4    <= d_s3;
			zero_s4 <= zero_s3;

			mag_par_s5  <= n_s4[NW-1] ? $unsigned(-n_s4) : $unsigned(n_s4);
			mag_perp_s5 <= m_s4[NW-1] ? $unsigned(-m_s4) : $unsigned(m_s4);
			den_s5      <= d_s4;
			flags_s5    <= '{zero: zero_s4, neg_par: n_s4[NW-1], neg_perp: m_s4[NW-1]};
		end
	end

endmodule

### rtl/tfap_div.sv
// Pipelined restoring divider pair, one quotient bit per stage for both results.
module tfap_div #(
	parameter int DW = 32,
	parameter int FW = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [DW+2*FW+3:0]                  mag_par,
	input  logic [DW+2*FW+3:0]                  mag_perp,
	input  logic [2*FW-1:0]                     den,
	input  tfap_pkg::flags_t                    flags,
	output logic                                out_valid,
	output logic [DW+tfap_pkg::QEXTRA-1:0]      q_par,
	output logic [DW+tfap_pkg::QEXTRA-1:0]      q_perp,
	output logic [2*FW:0]                       rem_par,
	output logic [2*FW:0]                       rem_perp,
	output logic [2*FW-1:0]                     den_out,
	output tfap_pkg::flags_t                    flags_out
);
	localparam int QW  = DW + tfap_pkg::QEXTRA;
	localparam int DD  = 2 * FW;
	localparam int DNW = DD + 1;

	logic                  v_s   [QW];
	logic [DNW-1:0]        rp_s  [QW];
	logic [DNW-1:0]        rq_s  [QW];
	logic [QW-1:0]         np_s  [QW];
	logic [QW-1:0]         nq_s  [QW];
	logic [QW-1:0]         qp_s  [QW];
	logic [QW-1:0]         qq_s  [QW];
	logic [DD-1:0]         d_s   [QW];
	tfap_pkg::flags_t      f_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic             v_in;
		logic [DNW-1:0]   rp_in, rq_in;
		logic [QW-1:0]    np_in, nq_in, qp_in, qq_in;
		logic [DD-1:0]    d_in;
		tfap_pkg::flags_t f_in;
		logic [DNW:0]     tp, tq, dp, dq;
		logic             gp, gq;

		if (k == 0) begin : g_first
			// The magnitudes stay below den * 2^QW, so the top part is already reduced.
			assign v_in  = in_valid;
			assign rp_in = DNW'(mag_par >> QW);
			assign rq_in = DNW'(mag_perp >> QW);
			assign np_in = mag_par[QW-1:0];
			assign nq_in = mag_perp[QW-1:0];
			assign qp_in = '0;
			assign qq_in = '0;
			assign d_in  = den;
			assign f_in  = flags;
		end else begin : g_next
			assign v_in  = v_s[k-1];
			assign rp_in = rp_s[k-1];
			assign rq_in = rq_s[k-1];
			assign np_in = np_s[k-1];
			assign nq_in = nq_s[k-1];
			assign qp_in = qp_s[k-1];
			assign qq_in = qq_s[k-1];
			assign d_in  = d_s[k-1];
			assign f_in  = f_s[k-1];
		end

		assign tp = {rp_in, np_in[QW-1-k]};
		assign tq = {rq_in, nq_in[QW-1-k]};
		assign dp = {2'b00, d_in};
		assign dq = {1'b0, d_in, 1'b0};
		assign gp = tp >= dp;
		assign gq = tq >= dq;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rp_s[k] <= gp ? DNW'(tp - dp) : DNW'(tp);
				rq_s[k] <= gq ? DNW'(tq - dq) : DNW'(tq);
				np_s[k] <= np_in;
				nq_s[k] <= nq_in;
				qp_s[k] <= {qp_in[QW-2:0], gp};
				qq_s[k] <= {qq_in[QW-2:0], gq};
				d_s[k]  <= d_in;
				f_s[k]  <= f_in;
			end
		end
	end

	assign out_valid = v_s[QW-1];
	assign q_par     = qp_s[QW-1];
	assign q_perp    = qq_s[QW-1];
	assign rem_par   = rp_s[QW-1];
	assign rem_perp  = rq_s[QW-1];
	assign den_out   = d_s[QW-1];
	assign flags_out = f_s[QW-1];

endmodule

### rtl/tfap_out.sv
// Rounding, saturation and the output register with its skid entry.
module tfap_out #(
	parameter int DW = 32,
	parameter int FW = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [DW+tfap_pkg::QEXTRA-1:0]   q_par,
	input  logic [DW+tfap_pkg::QEXTRA-1:0]   q_perp,
	input  logic [2*FW:0]                    rem_par,
	input  logic [2*FW:0]                    rem_perp,
	input  logic [2*FW-1:0]                  den,
	input  tfap_pkg::flags_t                 flags,
	input  logic                             m_tready,
	output logic                             en,
	output logic                             m_tvalid,
	output logic [DW-1:0]                    t_parallel,
	output logic [DW-1:0]                    t_perpendicular,
	output logic                             zero_field,
	output logic                             saturated
);
	localparam int QW  = DW + tfap_pkg::QEXTRA;
	localparam int RW  = 2 * DW + 2;
	localparam logic [QW:0] LIM = (QW+1)'(1) << (DW - 1);

	// Clip a rounded magnitude and apply its sign; bit DW of the result flags a clip.
	function automatic logic [DW:0] pack(input logic neg, input logic [QW:0] mag);
		logic          over;
		logic [QW:0]   clip;
		over = neg ? (mag > LIM) : (mag >= LIM);
		clip = over ? (neg ? LIM : LIM - (QW+1)'(1)) : mag;
		pack = {over, neg ? DW'(-clip) : DW'(clip)};
	endfunction

	logic            up_par, up_perp;
	logic [QW:0]     qr_par_c, qr_perp_c;

	// Round half away from zero on the magnitude: up when twice the remainder reaches the divisor.
	assign up_par    = {rem_par, 1'b0} >= {2'b00, den};
	assign up_perp   = {rem_perp, 1'b0} >= {1'b0, den, 1'b0};
	assign qr_par_c  = (QW+1)'(q_par) + (QW+1)'(up_par);
	assign qr_perp_c = (QW+1)'(q_perp) + (QW+1)'(up_perp);

	logic             v_s1;
	logic [QW:0]      qr_par_s1, qr_perp_s1;
	tfap_pkg::flags_t f_s1;

	logic [DW:0]      pk_par, pk_perp;
	logic [RW-1:0]    res_c;

	assign pk_par  = pack(f_s1.neg_par, qr_par_s1);
	assign pk_perp = pack(f_s1.neg_perp, qr_perp_s1);
	assign res_c = f_s1.zero ? {1'b0, 1'b1, {(2*DW){1'b0}}}
		: {pk_par[DW] | pk_perp[DW], 1'b0, pk_perp[DW-1:0], pk_par[DW-1:0]};

	logic             out_v_q, skid_v_q;
	logic [RW-1:0]    out_q, skid_q;

	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= in_valid;
			end
			if (skid_v_q) begin
				if (m_tready) begin
					skid_v_q <= 1'b0;
				end
			end else if (!out_v_q || m_tready) begin
				out_v_q <= v_s1;
			end else if (v_s1) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qr_par_s1  <= qr_par_c;
			qr_perp_s1 <= qr_perp_c;
			f_s1       <= flags;
		end
		if (skid_v_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || m_tready) begin
			out_q <= res_c;
		end else begin
			skid_q <= res_c;
		end
	end

	assign m_tvalid        = out_v_q;
	assign t_parallel      = out_q[DW-1:0];
	assign t_perpendicular = out_q[2*DW-1:DW];
	assign zero_field      = out_q[2*DW];
	assign saturated       = out_q[2*DW+1];

`ifndef ASSERT_OFF
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds a word while the output register is empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && m_tready |=> out_v_q && !skid_v_q)
		else $error("skid word was not moved to the output register");

	a_stall_catch: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !m_tready && v_s1 && !skid_v_q |=> skid_v_q && out_v_q)
		else $error("finished word was dropped during an output stall");

	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && zero_field |-> !saturated && t_parallel == '0 && t_perpendicular == '0)
		else $error("zero field word carries nonzero results");
`endif

endmodule

### rtl/tensor_field_aligned_projection.sv
// Top level of the field-aligned projection of a symmetric tensor.
// Takes one tensor (six Q-format components) and a field vector per word and returns
// the component along the field, N/|B|^2, and the mean of the two transverse diagonal
// entries, (trace*|B|^2 - N)/(2|B|^2), each rounded to nearest with ties away from zero
// and clipped to the output range. A new word is accepted every cycle while the skid
// entry of the output stage is empty. A word passes through five front stages (products,
// recombination, the perpendicular numerator and the magnitudes), one divider stage
// per quotient bit (DATA_WIDTH + 2 of them), a rounding stage and the output register.
// A two-entry output stage lets the input keep flowing while one result waits to be
// taken.
module tensor_field_aligned_projection #(
	parameter int DATA_WIDTH  = 32,
	parameter int FIELD_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// txx, tyy, tzz, txy, tyz, tzx, field_x, field_y, field_z from bit 0 up, zero padded
	input  logic [((6*DATA_WIDTH+3*FIELD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// t_parallel, t_perpendicular from bit 0 up, zero padded
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// zero_field, saturated from bit 0 up
	output logic [1:0] m_tuser
);
	localparam int DW  = DATA_WIDTH;
	localparam int FW  = FIELD_WIDTH;
	localparam int IW  = 6 * DW + 3 * FW;
	localparam int OW  = ((2 * DW + 7) / 8) * 8;
	localparam int NW  = DW + 2 * FW + 4;
	localparam int QW  = DW + tfap_pkg::QEXTRA;

	logic             en;
	logic             v_f;
	logic [NW-1:0]    mag_par, mag_perp;
	logic [2*FW-1:0]  den_f, den_d;
	tfap_pkg::flags_t flags_f, flags_d;
	logic             v_d;
	logic [QW-1:0]    q_par, q_perp;
	logic [2*FW:0]    rem_par, rem_perp;
	logic [DW-1:0]    t_parallel, t_perpendicular;
	logic             zero_field, saturated;

	assign s_tready = en;

	tfap_front #(.DW(DW), .FW(FW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.in_data    (s_tdata[IW-1:0]),
		.v_s5       (v_f),
		.mag_par_s5 (mag_par),
		.mag_perp_s5(mag_perp),
		.den_s5     (den_f),
		.flags_s5   (flags_f)
	);

	tfap_div #(.DW(DW), .FW(FW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_f),
		.mag_par  (mag_par),
		.mag_perp (mag_perp),
		.den      (den_f),
		.flags    (flags_f),
		.out_valid(v_d),
		.q_par    (q_par),
		.q_perp   (q_perp),
		.rem_par  (rem_par),
		.rem_perp (rem_perp),
		.den_out  (den_d),
		.flags_out(flags_d)
	);

	tfap_out #(.DW(DW), .FW(FW)) u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (v_d),
		.q_par          (q_par),
		.q_perp         (q_perp),
		.rem_par        (rem_par),
		.rem_perp       (rem_perp),
		.den            (den_d),
		.flags          (flags_d),
		.m_tready       (m_tready),
		.en             (en),
		.m_tvalid       (m_tvalid),
		.t_parallel     (t_parallel),
		.t_perpendicular(t_perpendicular),
		.zero_field     (zero_field),
		.saturated      (saturated)
	);

	assign m_tdata = OW'({t_perpendicular, t_parallel});
	assign m_tuser = {saturated, zero_field};

endmodule
